// ----- hw/rtl/particle_pool_update_defines.svh -----
// Assertion macros of the particle pool controller RTL.
`ifndef PARTICLE_POOL_UPDATE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_DEFINES_SVH
`ifndef SYNTH
// Check that a condition holds at every clock edge outside reset.
`define PP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("particle pool check failed");
// Check that a trigger is followed by a result in the next cycle.
`define PP_ASSERT_NEXT(lbl, trig, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error("particle pool sequence check failed");
`else
`define PP_ASSERT(lbl, expr)
`define PP_ASSERT_NEXT(lbl, trig, expr)
`endif
`endif

// ----- hw/rtl/ppu_pkg.sv -----
// Types, constants and arithmetic helpers of the particle pool update block.
package ppu_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIFE_TIME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIFE_RECIP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH_SIZE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEATH_SIZE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPAWN_POS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_SCALE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPAWN_VELOCITY = 3'd7;

  // register reset values
  localparam logic [31:0] EMIT_PERIOD_RST    = 32'd3277;
  localparam logic [31:0] LIFE_TIME_RST      = 32'd196608;
  localparam logic [31:0] LIFE_RECIP_RST     = 32'd21845;
  localparam logic [15:0] BIRTH_SIZE_RST     = 16'd256;
  localparam logic [15:0] DEATH_SIZE_RST     = 16'd768;
  localparam logic [47:0] SPAWN_POS_RST      = 48'h0;
  localparam logic [47:0] JITTER_SCALE_RST   = 48'h0100_0100_0100;
  localparam logic [47:0] SPAWN_VELOCITY_RST = 48'h0000_0200_0000;

  localparam logic [15:0] LFSR_RST   = 16'hACE1;
  localparam logic [15:0] ALPHA_PEAK = 16'd52429;

  // one pool entry
  typedef struct packed {
    logic [31:0] spawn_time;
    logic [31:0] init_x;
    logic [31:0] init_y;
    logic [31:0] init_z;
    logic [47:0] vel;
  } entry_t;

  // one result beat
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] quad_size;
    logic [15:0] alpha;
    logic        empty_res;
    logic        last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic spawn;
    logic rd_tail;
    logic eval;
    logic move;
    logic mul;
    logic size;
    logic push;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic spawn_due;
    logic has_entry;
    logic expired;
    logic out_free;
  } sts_t;

  // one right shift of the LFSR, feedback from bits 0, 2, 3 and 5
  function automatic logic [15:0] lfsr_step(input logic [15:0] l);
    logic b;
    b = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {b, l[15:1]};
  endfunction

  // spawn position of one axis: emitter pos plus jitter times (r - half)
  function automatic logic [31:0] spawn_axis(input logic [15:0] pos,
                                             input logic [15:0] jit,
                                             input logic [15:0] r);
    logic signed [16:0] rr;
    logic signed [33:0] jr;
    logic signed [31:0] base;
    logic signed [31:0] sh;
    rr   = $signed({1'b0, r}) - 17'sd32768;
    jr   = $signed({1'b0, jit}) * rr;
    sh   = 32'(jr >>> 8);
    base = 32'($signed({pos, 8'h00}));
    return 32'(base + sh);
  endfunction

  // initial position plus floored age*velocity, saturated to 32 bits
  function automatic logic [31:0] sat_pos(input logic [31:0] init,
                                          input logic signed [48:0] prod);
    logic signed [41:0] s;
    s = 42'($signed(init)) + 42'(prod >>> 8);
    if (s > 42'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (s < -42'sd2147483648) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

endpackage

// ----- hw/rtl/ppu_ctrl.sv -----
// Tick sequencer of the particle pool: spawn rounds, pool walk and flush.
`include "particle_pool_update_defines.svh"
module ppu_ctrl #(
  parameter int MAX_SPAWNS_PER_TICK = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ppu_pkg::sts_t sts,
  output ppu_pkg::cmd_t cmd
);

  localparam int RW = $clog2(MAX_SPAWNS_PER_TICK + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SPAWN = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_MOVE  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_SIZE  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;

  logic [3:0]    state, state_next;
  logic [RW-1:0] rounds, rounds_next;
  logic          rd_idx;

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next  = state;
    rounds_next = rounds;
    cmd         = '0;
    rd_idx      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept  = 1'b1;
          rounds_next = '0;
          state_next  = S_SPAWN;
        end
      end
      S_SPAWN: begin
        if (sts.spawn_due && rounds < RW'(MAX_SPAWNS_PER_TICK)) begin
          cmd.spawn   = 1'b1;
          rounds_next = rounds + 1'b1;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        rd_idx     = 1'b1;
        state_next = sts.has_entry ? S_EVAL : S_FLUSH;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.expired) begin
          cmd.rd_tail = 1'b1;
          state_next  = S_MOVE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MOVE: begin
        cmd.move   = 1'b1;
        state_next = S_RD;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SIZE;
      end
      S_SIZE: begin
        cmd.size   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_RD;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rounds <= '0;
    end else begin
      state  <= state_next;
      rounds <= rounds_next;
    end
  end

  `PP_ASSERT(a_spawn_bound, !(cmd.spawn && rounds >= RW'(MAX_SPAWNS_PER_TICK)))
  `PP_ASSERT(a_one_beat_src, !(cmd.push && cmd.flush))
  `PP_ASSERT_NEXT(a_flush_ends, cmd.flush, state == S_IDLE && !in_stall)
  `PP_ASSERT(a_read_only_walk, !(rd_idx && cmd.eval))

endmodule

// ----- hw/rtl/ppu_dp.sv -----
// Datapath of the particle pool: registers, pool memory, arithmetic and output beat.
module ppu_dp #(
  parameter int POOL_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppu_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [31:0]                      now_time,
  input  ppu_pkg::cmd_t                    cmd,
  output ppu_pkg::sts_t                    sts,
  input  logic                             out_stall,
  output logic                             out_valid,
  output ppu_pkg::res_t                    out_res
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);

  // configuration
  logic [31:0] emit_period, life_time, life_recip;
  logic [15:0] birth_size, death_size;
  logic [47:0] spawn_pos, jitter_scale, spawn_velocity;

  // tick state
  logic [31:0]   now_r, last_emit, last_emit_next;
  logic [15:0]   lfsr, l1, l2, l3;
  logic [CW-1:0] count, idx, tail;

  // pool memory
  ppu_pkg::entry_t mem [POOL_DEPTH];
  ppu_pkg::entry_t mem_q, new_ent, wdata;
  logic [AW-1:0]   raddr, waddr;
  logic            we, room;

  // arithmetic pipeline
  logic signed [32:0] age, age_r, age_abs;
  ppu_pkg::entry_t    ent_r;
  logic [63:0]        mag_r;
  logic               neg_r;
  logic signed [48:0] prod_x, prod_y, prod_z;
  logic [64:0]        mag_up;
  logic signed [49:0] p;
  logic signed [33:0] pl;
  logic signed [16:0] diff;
  logic signed [50:0] sprod_r, dd, ad;
  logic [15:0]        alpha_r;
  logic [31:0]        px_r, py_r, pz_r;
  logic signed [35:0] sz;
  logic [15:0]        size_val;

  // pending result
  ppu_pkg::res_t pend, cur, fin;
  logic          pend_valid;

  assign tail = count - 1'b1;
  assign room = (count < CW'(POOL_DEPTH));
  assign last_emit_next = last_emit + emit_period;

  // status to controller
  assign age = $signed({1'b0, now_r}) - $signed({1'b0, mem_q.spawn_time});
  always_comb begin
    sts.spawn_due = ({1'b0, now_r} > ({1'b0, last_emit} + {1'b0, emit_period}));
    sts.has_entry = (idx < count);
    sts.expired   = !age[32] && (age[31:0] > life_time);
    sts.out_free  = !out_valid || !out_stall;
  end

  // spawn entry from three LFSR steps
  always_comb begin
    l1 = ppu_pkg::lfsr_step(lfsr);
    l2 = ppu_pkg::lfsr_step(l1);
    l3 = ppu_pkg::lfsr_step(l2);
    new_ent.spawn_time = last_emit_next;
    new_ent.init_x     = ppu_pkg::spawn_axis(spawn_pos[15:0],  jitter_scale[15:0],  l1);
    new_ent.init_y     = ppu_pkg::spawn_axis(spawn_pos[31:16], jitter_scale[31:16], l2);
    new_ent.init_z     = ppu_pkg::spawn_axis(spawn_pos[47:32], jitter_scale[47:32], l3);
    new_ent.vel        = spawn_velocity;
  end

  // memory port selection
  always_comb begin
    raddr = cmd.rd_tail ? tail[AW-1:0] : idx[AW-1:0];
    we    = (cmd.spawn && room) || cmd.move;
    waddr = cmd.spawn ? count[AW-1:0] : idx[AW-1:0];
    wdata = cmd.spawn ? new_ent : mem_q;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_period    <= ppu_pkg::EMIT_PERIOD_RST;
      life_time      <= ppu_pkg::LIFE_TIME_RST;
      life_recip     <= ppu_pkg::LIFE_RECIP_RST;
      birth_size     <= ppu_pkg::BIRTH_SIZE_RST;
      death_size     <= ppu_pkg::DEATH_SIZE_RST;
      spawn_pos      <= ppu_pkg::SPAWN_POS_RST;
      jitter_scale   <= ppu_pkg::JITTER_SCALE_RST;
      spawn_velocity <= ppu_pkg::SPAWN_VELOCITY_RST;
      last_emit      <= '0;
      lfsr           <= ppu_pkg::LFSR_RST;
      count          <= '0;
      idx            <= '0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ppu_pkg::REG_EMIT_PERIOD:    emit_period    <= cfg_data[31:0];
          ppu_pkg::REG_LIFE_TIME:      life_time      <= cfg_data[31:0];
          ppu_pkg::REG_LIFE_RECIP:     life_recip     <= cfg_data[31:0];
          ppu_pkg::REG_BIRTH_SIZE:     birth_size     <= cfg_data[15:0];
          ppu_pkg::REG_DEATH_SIZE:     death_size     <= cfg_data[15:0];
          ppu_pkg::REG_SPAWN_POS:      spawn_pos      <= cfg_data;
          ppu_pkg::REG_JITTER_SCALE:   jitter_scale   <= cfg_data;
          ppu_pkg::REG_SPAWN_VELOCITY: spawn_velocity <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        idx <= '0;
      end
      // advance the emitter; drop the particle when the pool is full
      if (cmd.spawn) begin
        last_emit <= last_emit_next;
        lfsr      <= l3;
        if (room) begin
          count <= count + 1'b1;
        end
      end
      if (cmd.move) begin
        count <= tail;
      end
      if (cmd.push) begin
        idx <= idx + 1'b1;
      end
      // output beat register
      if (cmd.push) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end else if (!out_stall) begin
          out_valid <= 1'b0;
        end
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // arithmetic stages
  always_comb begin
    age_abs  = age_r[32] ? -age_r : age_r;
    mag_up   = {1'b0, mag_r} + 65'h0_0000_0000_0000_FFFF;
    p        = neg_r ? -$signed({1'b0, mag_up[64:16]}) : $signed({2'b00, mag_r[63:16]});
    if (p > 50'sd4294967296) begin
      pl = 34'sd4294967296;
    end else if (p < -50'sd4294967296) begin
      pl = -34'sd4294967296;
    end else begin
      pl = p[33:0];
    end
    diff     = $signed({1'b0, death_size}) - $signed({1'b0, birth_size});
    dd       = $signed({p, 1'b0}) - 51'sd65536;
    ad       = dd[50] ? -dd : dd;
    sz       = 36'($signed({1'b0, birth_size})) + 36'(sprod_r >>> 16);
    if (sz < 36'sd0) begin
      size_val = 16'd0;
    end else if (sz > 36'sd65535) begin
      size_val = 16'hFFFF;
    end else begin
      size_val = sz[15:0];
    end
    cur.pos_x     = px_r;
    cur.pos_y     = py_r;
    cur.pos_z     = pz_r;
    cur.quad_size = size_val;
    cur.alpha     = alpha_r;
    cur.empty_res = 1'b0;
    cur.last      = 1'b0;
    // final beat of a tick: the held result, or the empty marker
    if (pend_valid) begin
      fin = pend;
    end else begin
      fin           = '0;
      fin.empty_res = 1'b1;
    end
    fin.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r <= now_time;
    end
    if (cmd.eval) begin
      age_r <= age;
      ent_r <= mem_q;
    end
    if (cmd.mul) begin
      mag_r  <= age_abs[31:0] * life_recip;
      neg_r  <= age_r[32];
      prod_x <= age_r * $signed(ent_r.vel[15:0]);
      prod_y <= age_r * $signed(ent_r.vel[31:16]);
      prod_z <= age_r * $signed(ent_r.vel[47:32]);
    end
    if (cmd.size) begin
      sprod_r <= diff * pl;
      alpha_r <= (ad >= 51'sd52429) ? 16'd0 : 16'(51'($unsigned(ppu_pkg::ALPHA_PEAK)) - ad);
      px_r    <= ppu_pkg::sat_pos(ent_r.init_x, prod_x);
      py_r    <= ppu_pkg::sat_pos(ent_r.init_y, prod_y);
      pz_r    <= ppu_pkg::sat_pos(ent_r.init_z, prod_z);
    end
    // hold one result back so the final one can carry the last mark
    if (cmd.push) begin
      pend <= cur;
      if (pend_valid) begin
        out_res <= pend;
      end
    end
    if (cmd.flush) begin
      out_res <= fin;
    end
  end

endmodule

// ----- hw/rtl/particle_pool_update.sv -----
// Top level of the particle pool update block.
//
// Each input beat is a frame tick carrying now_time. The emitter first runs up
// to MAX_SPAWNS_PER_TICK spawn rounds, then the pool is walked in slot order
// and every live particle yields one output beat. The final beat of a tick
// has last set; an empty pool yields one beat with empty_res and last.
// Configuration writes (cfg_we, cfg_index, cfg_data) must be made only while
// the block is idle between ticks; the block itself does not enforce this.
// in_stall stays high from acceptance until the final beat is loaded.
// One result is held back in a pending register so the last mark can be set
// once the walk ends. When the receiver raises out_stall, the output beat holds
// and the walk waits in its output step. Reset restores the register defaults,
// empties the pool, clears last_emit and reloads the LFSR; no clearing pass.
module particle_pool_update #(
  parameter int POOL_DEPTH          = 64,
  parameter int MAX_SPAWNS_PER_TICK = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    now_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             pos_x,
  output logic signed [31:0]             pos_y,
  output logic signed [31:0]             pos_z,
  output logic [15:0]                    quad_size,
  output logic [15:0]                    alpha,
  output logic                           empty_res,
  output logic                           last
);

  ppu_pkg::cmd_t cmd;
  ppu_pkg::sts_t sts;
  ppu_pkg::res_t res;

  ppu_ctrl #(
    .MAX_SPAWNS_PER_TICK(MAX_SPAWNS_PER_TICK)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  ppu_dp #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .now_time (now_time),
    .cmd      (cmd),
    .sts      (sts),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_res  (res)
  );

  // unpack the output beat
  assign pos_x     = $signed(res.pos_x);
  assign pos_y     = $signed(res.pos_y);
  assign pos_z     = $signed(res.pos_z);
  assign quad_size = res.quad_size;
  assign alpha     = res.alpha;
  assign empty_res = res.empty_res;
  assign last      = res.last;

endmodule

// ----- tb/sv/particle_pool_update_test.sv -----
// Self-checking testbench of the particle pool update block.
module particle_pool_update_test;

  localparam int POOL_N    = 64;
  localparam int SPAWN_MAX = 10;
  localparam int LIMIT     = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ppu_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] now_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [15:0] quad_size, alpha;
  logic        empty_res, last;

  particle_pool_update u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .now_time(now_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .quad_size(quad_size), .alpha(alpha), .empty_res(empty_res), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow registers and pool of the emitter
  logic [31:0] s_period, s_life, s_recip;
  logic [15:0] s_birth, s_death;
  logic [47:0] s_pos, s_jit, s_vel;
  int          pool_live;
  logic [31:0] pool_emit;
  logic [15:0] pool_lfsr;
  logic [31:0] pool_time [POOL_N];
  logic [31:0] pool_x [POOL_N];
  logic [31:0] pool_y [POOL_N];
  logic [31:0] pool_z [POOL_N];
  logic [47:0] pool_vel [POOL_N];

  ppu_pkg::res_t beat_q [$];
  logic [31:0] tick_q [$];
  int          sent_n = 0;
  int          taken_n = 0;
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  int          hold_ask = 0;

  function automatic logic [15:0] lfsr_advance(logic [15:0] l);
    return {l[0] ^ l[2] ^ l[3] ^ l[5], l[15:1]};
  endfunction

  function automatic logic [31:0] jitter_axis(int k);
    longint r, j, v;
    pool_lfsr = lfsr_advance(pool_lfsr);
    r = longint'({48'b0, pool_lfsr}) - 32768;
    j = longint'({48'b0, s_jit[16*k +: 16]});
    v = longint'($signed(s_pos[16*k +: 16])) * 256 + ((j * r) >>> 8);
    return v[31:0];
  endfunction

  function automatic logic [31:0] moved_axis(logic [31:0] init, logic [15:0] v, longint age);
    longint s;
    s = longint'($signed(init)) + ((age * longint'($signed(v))) >>> 8);
    if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  // spawn rounds, then walk the pool and queue one beat per live particle
  function automatic void predict_tick(logic [31:0] now);
    int rounds, i, t, n;
    logic [31:0] x, y, z;
    longint age, a, p, pl, size, d, al;
    longint unsigned mag;
    ppu_pkg::res_t r, held;
    rounds = 0;
    n = 0;
    while ({32'b0, now} > {32'b0, pool_emit} + {32'b0, s_period} && rounds < SPAWN_MAX) begin
      rounds++;
      pool_emit = pool_emit + s_period;
      x = jitter_axis(0);
      y = jitter_axis(1);
      z = jitter_axis(2);
      if (pool_live < POOL_N) begin
        pool_x[pool_live] = x;
        pool_y[pool_live] = y;
        pool_z[pool_live] = z;
        pool_vel[pool_live] = s_vel;
        pool_time[pool_live] = pool_emit;
        pool_live++;
      end
    end
    i = 0;
    while (i < pool_live) begin
      age = longint'({32'b0, now}) - longint'({32'b0, pool_time[i]});
      if (age > longint'({32'b0, s_life})) begin
        // drop: move the tail entry into this slot and examine it next
        t = pool_live - 1;
        pool_time[i] = pool_time[t];
        pool_x[i] = pool_x[t];
        pool_y[i] = pool_y[t];
        pool_z[i] = pool_z[t];
        pool_vel[i] = pool_vel[t];
        pool_live = t;
        continue;
      end
      a = age < 0 ? -age : age;
      mag = longint'(unsigned'(a)) * longint'({32'b0, s_recip});
      if (age >= 0) p = longint'(mag >> 16);
      else p = -longint'((mag + 64'hFFFF) >> 16);
      pl = p > 64'sd4294967296 ? 64'sd4294967296 : (p < -64'sd4294967296 ? -64'sd4294967296 : p);
      size = longint'({48'b0, s_birth}) +
             (((longint'({48'b0, s_death}) - longint'({48'b0, s_birth})) * pl) >>> 16);
      size = size < 0 ? 0 : (size > 65535 ? 65535 : size);
      d = 2 * p - 65536;
      if (d < 0) d = -d;
      al = 52429 - d;
      al = al < 0 ? 0 : al;
      r.pos_x = moved_axis(pool_x[i], pool_vel[i][15:0], age);
      r.pos_y = moved_axis(pool_y[i], pool_vel[i][31:16], age);
      r.pos_z = moved_axis(pool_z[i], pool_vel[i][47:32], age);
      r.quad_size = size[15:0];
      r.alpha = al[15:0];
      r.empty_res = 1'b0;
      r.last = 1'b0;
      // hold one beat back so the final one can take the last mark
      if (n > 0) beat_q.push_back(held);
      held = r;
      n++;
      i++;
    end
    if (n == 0) begin
      held = '0;
      held.empty_res = 1'b1;
    end
    held.last = 1'b1;
    beat_q.push_back(held);
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
    end
  endtask

  // driver: feed pending ticks with random gaps
  int gap = 0;
  always @(posedge clk) begin : drive
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        predict_tick(now_time);
        taken_n++;
        nv = 1'b0;
        gap = quiet ? 0 : $urandom_range(0, 10);
      end
      if (!nv) begin
        if (gap > 0) begin
          gap--;
        end else if (tick_q.size() > 0) begin
          now_time <= tick_q.pop_front();
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  // long receiver hold-off, counted on its own
  int hold_cnt = 0;
  int hold_seen = 0;
  always @(posedge clk) begin : hold_off
    if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_cnt  <= 900;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor: compare beats and stall at random
  int stall_cnt = 0;
  always @(posedge clk) begin : watch
    ppu_pkg::res_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (beat_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual pos_x %0h", $time, pos_x);
        end else begin
          e = beat_q.pop_front();
          check_field("pos_x", e.pos_x, $unsigned(pos_x));
          check_field("pos_y", e.pos_y, $unsigned(pos_y));
          check_field("pos_z", e.pos_z, $unsigned(pos_z));
          check_field("quad_size", e.quad_size, quad_size);
          check_field("alpha", e.alpha, alpha);
          check_field("empty_res", e.empty_res, empty_res);
          check_field("last", e.last, last);
        end
        stall_cnt = quiet ? 0 : $urandom_range(0, 10);
      end
      if (stall_cnt > 0) stall_cnt--;
    end
    out_stall <= (stall_cnt > 0) || (hold_cnt > 0);
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [ppu_pkg::CFG_IDX_W-1:0] idx, logic [47:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      ppu_pkg::REG_EMIT_PERIOD:    s_period = v[31:0];
      ppu_pkg::REG_LIFE_TIME:      s_life = v[31:0];
      ppu_pkg::REG_LIFE_RECIP:     s_recip = v[31:0];
      ppu_pkg::REG_BIRTH_SIZE:     s_birth = v[15:0];
      ppu_pkg::REG_DEATH_SIZE:     s_death = v[15:0];
      ppu_pkg::REG_SPAWN_POS:      s_pos = v;
      ppu_pkg::REG_JITTER_SCALE:   s_jit = v;
      ppu_pkg::REG_SPAWN_VELOCITY: s_vel = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] per, logic [31:0] lt, logic [31:0] rc,
                           logic [15:0] bs, logic [15:0] ds,
                           logic [47:0] sp, logic [47:0] jt, logic [47:0] sv);
    write_reg(ppu_pkg::REG_EMIT_PERIOD, {16'b0, per});
    write_reg(ppu_pkg::REG_LIFE_TIME, {16'b0, lt});
    write_reg(ppu_pkg::REG_LIFE_RECIP, {16'b0, rc});
    write_reg(ppu_pkg::REG_BIRTH_SIZE, {32'b0, bs});
    write_reg(ppu_pkg::REG_DEATH_SIZE, {32'b0, ds});
    write_reg(ppu_pkg::REG_SPAWN_POS, sp);
    write_reg(ppu_pkg::REG_JITTER_SCALE, jt);
    write_reg(ppu_pkg::REG_SPAWN_VELOCITY, sv);
  endtask

  task automatic send(logic [31:0] t);
    tick_q.push_back(t);
    sent_n++;
  endtask

  // wait for every tick taken and every beat seen, then settle
  task automatic drain();
    while (taken_n != sent_n || beat_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  // random ticks: mostly advancing time, some backward steps and wild values
  task automatic random_ticks(int n, int step_max);
    logic [31:0] cur;
    int k, pick;
    cur = pool_emit;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) cur = cur + $urandom_range(0, step_max);
      else if (pick < 95) cur = cur - $urandom_range(0, step_max * 4);
      else cur = $urandom();
      send(cur);
    end
  endtask

  initial begin : run
    int ph;
    s_period = ppu_pkg::EMIT_PERIOD_RST;
    s_life = ppu_pkg::LIFE_TIME_RST;
    s_recip = ppu_pkg::LIFE_RECIP_RST;
    s_birth = ppu_pkg::BIRTH_SIZE_RST;
    s_death = ppu_pkg::DEATH_SIZE_RST;
    s_pos = ppu_pkg::SPAWN_POS_RST;
    s_jit = ppu_pkg::JITTER_SCALE_RST;
    s_vel = ppu_pkg::SPAWN_VELOCITY_RST;
    pool_live = 0;
    pool_emit = '0;
    pool_lfsr = ppu_pkg::LFSR_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pool, single spawn, spawn cap, backward time, expiry, wrap
    send(32'd0);
    send(32'd100);
    send(32'd3278);
    send(32'd3278);
    send(32'd20000);
    send(32'd200000);
    send(32'd150000);
    send(32'd500000);
    send(32'd900000);
    send(32'hFFFF_FFFF);
    send(32'd0);
    send(32'h8000_0000);
    drain();

    // zero period and zero reciprocal, extreme sizes and positions
    write_all(32'd0, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 16'h0000,
              48'h7FFF_8000_FFFF, 48'hFFFF_FFFF_FFFF, 48'h8000_7FFF_0001);
    send(32'd10);
    send(32'd20);
    send(32'd5);
    drain();

    // fill the pool and saturate everything
    write_all(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF,
              48'h8000_7FFF_8000, 48'hFFFF_0000_FFFF, 48'h7FFF_8000_7FFF);
    for (int k = 0; k < 9; k++) send(pool_emit + 32'd1000 * (k + 1));
    send(32'hFFFF_FFFF);
    send(32'd0);
    drain();

    // random phases; one of them holds the receiver off for a long stretch
    for (ph = 0; ph < 7; ph++) begin
      quiet = (ph == 2);
      write_all($urandom_range(1, 40000), $urandom_range(1, 400000), $urandom(),
                16'($urandom()), 16'($urandom()), rand48(), rand48(), rand48());
      if (ph == 4) hold_ask++;
      random_ticks(55, $urandom_range(500, 30000));
      drain();
    end

    // periods too long to ever spawn
    quiet = 1'b0;
    write_all(32'hFFFF_FFFF, 32'd1, 32'd1, 16'd0, 16'd0, 48'd0, 48'd0, 48'd0);
    random_ticks(8, 50000);
    drain();

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ppu_pkg.sv
hw/rtl/ppu_ctrl.sv
hw/rtl/ppu_dp.sv
hw/rtl/particle_pool_update.sv
tb/sv/particle_pool_update_test.sv
